/* sv/bgc_pkg.sv */
package bgc_pkg;

  localparam int BUTTONS = 4;
  localparam int BTN_AW  = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

  localparam logic [3:0] G_PRESS         = 4'd0;
  localparam logic [3:0] G_SINGLE        = 4'd1;
  localparam logic [3:0] G_DOUBLE        = 4'd2;
  localparam logic [3:0] G_TRIPLE        = 4'd3;
  localparam logic [3:0] G_LONG1         = 4'd4;
  localparam logic [3:0] G_LONG2         = 4'd5;
  localparam logic [3:0] G_HOLD_ON       = 4'd6;
  localparam logic [3:0] G_RELEASE       = 4'd7;
  localparam logic [3:0] G_HOLD_OFF      = 4'd8;
  localparam logic [3:0] G_HOLD_OFF1     = 4'd9;
  localparam logic [3:0] G_HOLD_OFF2     = 4'd10;
  localparam logic [3:0] G_HOLD_OFF_LONG = 4'd11;

  localparam logic [8:0] IDLE_T0 = 9'd10;
  localparam logic [8:0] IDLE_T1 = 9'd100;
  localparam logic [8:0] IDLE_T2 = 9'd200;

  localparam logic [2:0] REG_PRESS_DEBOUNCE    = 3'd0;
  localparam logic [2:0] REG_RELEASE_DEBOUNCE  = 3'd1;
  localparam logic [2:0] REG_SINGLE_PRESS_MAX  = 3'd2;
  localparam logic [2:0] REG_LONG_PRESS_FIRST  = 3'd3;
  localparam logic [2:0] REG_LONG_PRESS_SECOND = 3'd4;
  localparam logic [2:0] REG_HOLD_ON_TICKS     = 3'd5;
  localparam logic [2:0] REG_CLICK_WINDOW      = 3'd6;
  localparam logic [2:0] REG_IDLE_LONG_TICKS   = 3'd7;

  typedef struct packed {
    logic [3:0] button;
    logic       level_released;
  } in_t;

  typedef struct packed {
    logic [3:0]  gesture;
    logic [15:0] press_time;
  } out_t;

  typedef struct packed {
    logic [3:0]  gesture_state;
    logic [8:0]  release_ticks;
    logic [15:0] press_ticks;
    logic [5:0]  window_ticks;
    logic [7:0]  click_count;
    logic        sampling;
  } btn_state_t;

  localparam int STATE_W = $bits(btn_state_t);

  localparam btn_state_t STATE_RESET = '{
    gesture_state: G_RELEASE,
    release_ticks: 9'd0,
    press_ticks:   16'd0,
    window_ticks:  6'd0,
    click_count:   8'd0,
    sampling:      1'b0
  };

  typedef struct packed {
    logic [7:0]  press_debounce;
    logic [7:0]  release_debounce;
    logic [9:0]  single_press_max;
    logic [15:0] long_press_first;
    logic [15:0] long_press_second;
    logic [15:0] hold_on_ticks;
    logic [5:0]  click_window;
    logic [8:0]  idle_long_ticks;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    press_debounce:    8'd2,
    release_debounce:  8'd2,
    single_press_max:  10'd10,
    long_press_first:  16'd200,
    long_press_second: 16'd300,
    hold_on_ticks:     16'd1000,
    click_window:      6'd40,
    idle_long_ticks:   9'd400
  };

endpackage

/* sv/bgc_ram.sv */
module bgc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/button_gesture_classifier.sv */
// Button gesture classifier.
// in_valid/in_stall/in_data: one sample tick per request, button index and
//   level (1 = released). A request is taken when in_valid is high and
//   in_stall is low.
// out_valid/out_stall/out_data: one result per request, in order: the
//   button's new gesture code and its press time.
// cfg_valid/cfg_ready/cfg_index/cfg_data: register writes, always ready;
//   write only while no request is in flight.
// The result is registered after the compute stage. Throughput: one request
//   per cycle unless in_stall is high; per-button state sits in a RAM read
//   in the cycle before a single read-modify-write stage, with the previous
//   write forwarded when back-to-back requests hit the same button.
// Reset: registers take their defaults and every button reads as released
//   with zeroed counters; no clearing pass is needed.
// Out-of-range button index: result is release with press time 0, no
//   state change.
// While out_stall holds a result, one more request still enters the
//   compute stage; in_stall rises only when that stage is also full.
module button_gesture_classifier (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bgc_pkg::in_t       in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bgc_pkg::out_t      out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  bgc_pkg::cfg_regs_t cfg;

  logic                       s1_valid;
  logic                       s1_in_range;
  logic                       s1_level;
  logic [bgc_pkg::BTN_AW-1:0] s1_addr;
  logic                       s1_byp;
  logic                       s1_adv;
  logic                       in_accept;
  logic                       in_range;
  logic [bgc_pkg::BTN_AW-1:0] in_addr;

  logic                       ram_we;
  logic [bgc_pkg::STATE_W-1:0] ram_rdata;
  bgc_pkg::btn_state_t        fwd_state;
  logic [bgc_pkg::BUTTONS-1:0] entry_valid;

  bgc_pkg::btn_state_t cur;
  bgc_pkg::btn_state_t state_next;
  bgc_pkg::out_t       result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= bgc_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bgc_pkg::REG_PRESS_DEBOUNCE:    cfg.press_debounce    <= cfg_data[7:0];
        bgc_pkg::REG_RELEASE_DEBOUNCE:  cfg.release_debounce  <= cfg_data[7:0];
        bgc_pkg::REG_SINGLE_PRESS_MAX:  cfg.single_press_max  <= cfg_data[9:0];
        bgc_pkg::REG_LONG_PRESS_FIRST:  cfg.long_press_first  <= cfg_data;
        bgc_pkg::REG_LONG_PRESS_SECOND: cfg.long_press_second <= cfg_data;
        bgc_pkg::REG_HOLD_ON_TICKS:     cfg.hold_on_ticks     <= cfg_data;
        bgc_pkg::REG_CLICK_WINDOW:      cfg.click_window      <= cfg_data[5:0];
        bgc_pkg::REG_IDLE_LONG_TICKS:   cfg.idle_long_ticks   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  assign s1_adv    = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !s1_adv;
  assign in_accept = in_valid && !in_stall;
  assign in_range  = {1'b0, in_data.button} < 5'(bgc_pkg::BUTTONS);
  assign in_addr   = in_data.button[bgc_pkg::BTN_AW-1:0];
  assign ram_we    = s1_valid && s1_adv && s1_in_range;

  bgc_ram #(
    .WIDTH (bgc_pkg::STATE_W),
    .DEPTH (bgc_pkg::BUTTONS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (state_next),
    .re    (in_accept),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      entry_valid <= '0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (ram_we) begin
        entry_valid[s1_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_in_range <= in_range;
      s1_level    <= in_data.level_released;
      s1_addr     <= in_addr;
      s1_byp      <= ram_we && (s1_addr == in_addr);
    end
    if (ram_we) begin
      fwd_state <= state_next;
    end
  end

  always_comb begin
    if (s1_byp) begin
      cur = fwd_state;
    end else if (entry_valid[s1_addr]) begin
      cur = bgc_pkg::btn_state_t'(ram_rdata);
    end else begin
      cur = bgc_pkg::STATE_RESET;
    end
  end

  always_comb begin
    logic [3:0]  st;
    logic [8:0]  rt;
    logic [15:0] pt;
    logic [5:0]  wt;
    logic [7:0]  cc;
    logic        smp;
    st  = cur.gesture_state;
    rt  = cur.release_ticks;
    pt  = cur.press_ticks;
    wt  = cur.window_ticks;
    cc  = cur.click_count;
    smp = cur.sampling;

    if (s1_level) begin
      if (st <= bgc_pkg::G_HOLD_ON) begin
        if (rt >= {1'b0, cfg.release_debounce}) st = bgc_pkg::G_RELEASE;
      end else if (st == bgc_pkg::G_RELEASE) begin
        if (rt >= bgc_pkg::IDLE_T0) st = bgc_pkg::G_HOLD_OFF;
      end else if (st == bgc_pkg::G_HOLD_OFF) begin
        if (rt >= bgc_pkg::IDLE_T1) st = bgc_pkg::G_HOLD_OFF1;
      end else if (st == bgc_pkg::G_HOLD_OFF1) begin
        if (rt >= bgc_pkg::IDLE_T2) st = bgc_pkg::G_HOLD_OFF2;
      end else if (st == bgc_pkg::G_HOLD_OFF2) begin
        if (rt >= cfg.idle_long_ticks) st = bgc_pkg::G_HOLD_OFF_LONG;
      end
      if (rt < cfg.idle_long_ticks) rt = rt + 9'd1;
      pt = 16'd0;
    end else begin
      if (st == bgc_pkg::G_RELEASE) begin
        rt = 9'd0;
        if ({2'b00, wt} >= cfg.press_debounce) begin
          st = bgc_pkg::G_PRESS;
          if (cc != 8'hFF) cc = cc + 8'd1;
        end
        smp = 1'b1;
      end else if (st >= bgc_pkg::G_HOLD_OFF && st <= bgc_pkg::G_HOLD_OFF_LONG) begin
        st = bgc_pkg::G_RELEASE;
      end
      if (pt != 16'hFFFF) pt = pt + 16'd1;
    end

    if (smp && wt != 6'd63) wt = wt + 6'd1;
    if (wt >= cfg.click_window) begin
      if (cc == 8'd1 && pt <= {6'd0, cfg.single_press_max}) st = bgc_pkg::G_SINGLE;
      if (cc == 8'd2) st = bgc_pkg::G_DOUBLE;
      if (cc == 8'd3) st = bgc_pkg::G_TRIPLE;
      cc  = 8'd0;
      wt  = 6'd0;
      smp = 1'b0;
    end

    priority if (pt >= cfg.hold_on_ticks) begin
      st = bgc_pkg::G_HOLD_ON;
    end else if (pt >= cfg.long_press_second) begin
      st = bgc_pkg::G_LONG2;
    end else if (pt >= cfg.long_press_first) begin
      st = bgc_pkg::G_LONG1;
    end else begin
      st = st;
    end

    state_next.gesture_state = st;
    state_next.release_ticks = rt;
    state_next.press_ticks   = pt;
    state_next.window_ticks  = wt;
    state_next.click_count   = cc;
    state_next.sampling      = smp;

    if (s1_in_range) begin
      result.gesture    = st;
      result.press_time = pt;
    end else begin
      result.gesture    = bgc_pkg::G_RELEASE;
      result.press_time = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      out_data <= result;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled with a free stage");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> s1_valid)
    else $error("accepted request lost before compute stage");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (s1_valid && s1_in_range))
    else $error("state write for out-of-range button");

  a_out_of_range_result: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_adv && !s1_in_range) |=>
      (out_valid && out_data.gesture == bgc_pkg::G_RELEASE && out_data.press_time == 16'd0))
    else $error("out-of-range button gave wrong result");
`endif

endmodule

/* dv/button_gesture_classifier_test.sv */
`timescale 1ns / 100ps

module button_gesture_classifier_test;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [8:0] REL_TO_HOLD_OFF  = 9'd10;
  localparam logic [8:0] REL_TO_HOLD_OFF1 = 9'd100;
  localparam logic [8:0] REL_TO_HOLD_OFF2 = 9'd200;

  class gesture_board;
    bgc_pkg::cfg_regs_t cfg;
    bgc_pkg::btn_state_t btn [bgc_pkg::BUTTONS];
    bgc_pkg::out_t due_results [$];
    int fail_count;

    function new();
      cfg.press_debounce    = 8'd2;
      cfg.release_debounce  = 8'd2;
      cfg.single_press_max  = 10'd10;
      cfg.long_press_first  = 16'd200;
      cfg.long_press_second = 16'd300;
      cfg.hold_on_ticks     = 16'd1000;
      cfg.click_window      = 6'd40;
      cfg.idle_long_ticks   = 9'd400;
      foreach (btn[b]) begin
        btn[b] = '0;
        btn[b].gesture_state = bgc_pkg::G_RELEASE;
      end
      fail_count = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        bgc_pkg::REG_PRESS_DEBOUNCE:    cfg.press_debounce    = val[7:0];
        bgc_pkg::REG_RELEASE_DEBOUNCE:  cfg.release_debounce  = val[7:0];
        bgc_pkg::REG_SINGLE_PRESS_MAX:  cfg.single_press_max  = val[9:0];
        bgc_pkg::REG_LONG_PRESS_FIRST:  cfg.long_press_first  = val;
        bgc_pkg::REG_LONG_PRESS_SECOND: cfg.long_press_second = val;
        bgc_pkg::REG_HOLD_ON_TICKS:     cfg.hold_on_ticks     = val;
        bgc_pkg::REG_CLICK_WINDOW:      cfg.click_window      = val[5:0];
        bgc_pkg::REG_IDLE_LONG_TICKS:   cfg.idle_long_ticks   = val[8:0];
        default: ;
      endcase
    endfunction

    function bgc_pkg::out_t next_gesture(bgc_pkg::in_t item);
      bgc_pkg::btn_state_t s;
      logic [3:0] g;
      logic [8:0] rt;
      logic [15:0] pt;
      bgc_pkg::out_t r;
      if (item.button >= bgc_pkg::BUTTONS) begin
        r.gesture = bgc_pkg::G_RELEASE;
        r.press_time = 16'd0;
        return r;
      end
      s = btn[item.button];
      g = s.gesture_state;
      rt = s.release_ticks;
      pt = s.press_ticks;
      if (item.level_released) begin
        if (g <= bgc_pkg::G_HOLD_ON) begin
          if (rt >= cfg.release_debounce) g = bgc_pkg::G_RELEASE;
        end else if (g == bgc_pkg::G_RELEASE) begin
          if (rt >= REL_TO_HOLD_OFF) g = bgc_pkg::G_HOLD_OFF;
        end else if (g == bgc_pkg::G_HOLD_OFF) begin
          if (rt >= REL_TO_HOLD_OFF1) g = bgc_pkg::G_HOLD_OFF1;
        end else if (g == bgc_pkg::G_HOLD_OFF1) begin
          if (rt >= REL_TO_HOLD_OFF2) g = bgc_pkg::G_HOLD_OFF2;
        end else if (g == bgc_pkg::G_HOLD_OFF2) begin
          if (rt >= cfg.idle_long_ticks) g = bgc_pkg::G_HOLD_OFF_LONG;
        end
        if (rt < cfg.idle_long_ticks) rt = rt + 9'd1;
        pt = 16'd0;
      end else begin
        if (g == bgc_pkg::G_RELEASE) begin
          rt = 9'd0;
          if (s.window_ticks >= cfg.press_debounce) begin
            g = bgc_pkg::G_PRESS;
            if (s.click_count != 8'hFF) s.click_count = s.click_count + 8'd1;
          end
          s.sampling = 1'b1;
        end else if (g >= bgc_pkg::G_HOLD_OFF && g <= bgc_pkg::G_HOLD_OFF_LONG) begin
          g = bgc_pkg::G_RELEASE;
        end
        if (pt != 16'hFFFF) pt = pt + 16'd1;
      end
      if (s.sampling && s.window_ticks != 6'd63) s.window_ticks = s.window_ticks + 6'd1;
      if (s.window_ticks >= cfg.click_window) begin
        if (s.click_count == 8'd1 && pt <= cfg.single_press_max) g = bgc_pkg::G_SINGLE;
        if (s.click_count == 8'd2) g = bgc_pkg::G_DOUBLE;
        if (s.click_count == 8'd3) g = bgc_pkg::G_TRIPLE;
        s.click_count = 8'd0;
        s.window_ticks = 6'd0;
        s.sampling = 1'b0;
      end
      if (pt >= cfg.hold_on_ticks) g = bgc_pkg::G_HOLD_ON;
      else if (pt >= cfg.long_press_second) g = bgc_pkg::G_LONG2;
      else if (pt >= cfg.long_press_first) g = bgc_pkg::G_LONG1;
      s.gesture_state = g;
      s.release_ticks = rt;
      s.press_ticks = pt;
      btn[item.button] = s;
      r.gesture = g;
      r.press_time = pt;
      return r;
    endfunction

    function void note_tick(bgc_pkg::in_t item);
      due_results.push_back(next_gesture(item));
    endfunction

    function void check_result(bgc_pkg::out_t got);
      bgc_pkg::out_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual gesture %0d press_time %0d",
                 $time, got.gesture, got.press_time);
        fail_count++;
        return;
      end
      want = due_results.pop_front();
      if (got.gesture !== want.gesture) begin
        $display("%0t: gesture mismatch, expected %0d actual %0d",
                 $time, want.gesture, got.gesture);
        fail_count++;
      end
      if (got.press_time !== want.press_time) begin
        $display("%0t: press_time mismatch, expected %0d actual %0d",
                 $time, want.press_time, got.press_time);
        fail_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  bgc_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bgc_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  gesture_board board = new();
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int hold_asked = 0;
  int unsigned cycles = 0;
  logic lvl_now [bgc_pkg::BUTTONS] = '{default: 1'b1};
  int run_left [bgc_pkg::BUTTONS] = '{default: 0};

  button_gesture_classifier dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // valid stays high after acceptance so back-to-back requests never toggle it
  task automatic send_tick(input bgc_pkg::in_t item);
    int gap;
    gap = send_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    board.note_tick(item);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(input bgc_pkg::cfg_regs_t c);
    logic [2:0] idx [8] = '{bgc_pkg::REG_PRESS_DEBOUNCE, bgc_pkg::REG_RELEASE_DEBOUNCE,
                            bgc_pkg::REG_SINGLE_PRESS_MAX, bgc_pkg::REG_LONG_PRESS_FIRST,
                            bgc_pkg::REG_LONG_PRESS_SECOND, bgc_pkg::REG_HOLD_ON_TICKS,
                            bgc_pkg::REG_CLICK_WINDOW, bgc_pkg::REG_IDLE_LONG_TICKS};
    logic [15:0] vals [8];
    vals[0] = {8'd0, c.press_debounce};
    vals[1] = {8'd0, c.release_debounce};
    vals[2] = {6'd0, c.single_press_max};
    vals[3] = c.long_press_first;
    vals[4] = c.long_press_second;
    vals[5] = c.hold_on_ticks;
    vals[6] = {10'd0, c.click_window};
    vals[7] = {7'd0, c.idle_long_ticks};
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      board.write_reg(idx[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic bgc_pkg::cfg_regs_t phase_config(input int ph);
    bgc_pkg::cfg_regs_t c;
    case (ph)
      1: c = '{8'd255, 8'd255, 10'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63, 9'd511};
      3: c = '0;
      5: c = '{8'd2, 8'd2, 10'd10, 16'd200, 16'd300, 16'd1000, 6'd40, 9'd400};
      default: begin
        c.press_debounce    = 8'($urandom_range(0, 5));
        c.release_debounce  = 8'($urandom_range(0, 5));
        c.single_press_max  = 10'($urandom_range(0, 25));
        c.long_press_first  = 16'($urandom_range(0, 50));
        c.long_press_second = c.long_press_first + 16'($urandom_range(0, 50));
        c.hold_on_ticks     = c.long_press_second + 16'($urandom_range(0, 80));
        c.click_window      = 6'($urandom_range(0, 63));
        c.idle_long_ticks   = 9'($urandom_range(0, 300));
      end
    endcase
    return c;
  endfunction

  function automatic int pick_run();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(1, 8);
    if (r < 93) return $urandom_range(9, 60);
    return $urandom_range(61, 450);
  endfunction

  // press/release runs per button, interleaved, with some stray levels
  task automatic random_phase(input int count);
    int b;
    int last_b;
    bgc_pkg::in_t t;
    last_b = 0;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 4) begin
        if ($urandom_range(0, 9) == 0) b = $urandom_range(bgc_pkg::BUTTONS, 15);
        else b = $urandom_range(0, bgc_pkg::BUTTONS - 1);
      end else begin
        b = last_b;
      end
      last_b = b;
      t.button = b[3:0];
      if (b >= bgc_pkg::BUTTONS || $urandom_range(0, 9) == 0) begin
        t.level_released = 1'($urandom_range(0, 1));
      end else begin
        if (run_left[b] == 0) begin
          lvl_now[b] = ~lvl_now[b];
          run_left[b] = pick_run();
        end
        run_left[b]--;
        t.level_released = lvl_now[b];
      end
      send_tick(t);
    end
  endtask

  initial begin
    int hold_served;
    int n;
    hold_served = 0;
    wait (rst == 1'b0);
    forever begin
      if (hold_served != hold_asked) begin
        n = 300;
        hold_served++;
      end else begin
        n = recv_idle ? $urandom_range(0, 19) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      board.check_result(out_data);
    end
  end

  initial begin
    bgc_pkg::in_t script [22] = '{
      '{4'd0, 1'b0}, '{4'd0, 1'b0}, '{4'd0, 1'b0}, '{4'd0, 1'b1}, '{4'd0, 1'b1},
      '{4'd0, 1'b1}, '{4'd0, 1'b0}, '{4'd1, 1'b0}, '{4'd0, 1'b1}, '{4'd15, 1'b0},
      '{4'd4, 1'b1}, '{4'd8, 1'b0}, '{4'd3, 1'b0}, '{4'd3, 1'b0}, '{4'd3, 1'b1},
      '{4'd2, 1'b1}, '{4'd2, 1'b0}, '{4'd1, 1'b1}, '{4'd7, 1'b1}, '{4'd0, 1'b0},
      '{4'd0, 1'b1}, '{4'd12, 1'b0}};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) send_tick(script[i]);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      load_config(phase_config(ph));
      send_idle = ($urandom_range(0, 2) != 0);
      recv_idle = ($urandom_range(0, 2) != 0);
      if (ph == 2) begin
        send_idle = 1'b0;
        hold_asked++;
      end
      random_phase(230);
      wait_idle();
    end

    // release counter cap
    send_idle = 1'b0;
    recv_idle = 1'b0;
    load_config('{8'd0, 8'd0, 10'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63, 9'd12});
    for (int k = 0; k < 6; k++) send_tick('{button: 4'd1, level_released: 1'b0});
    for (int k = 0; k < 30; k++) send_tick('{button: 4'd1, level_released: 1'b1});
    wait_idle();

    if (board.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
